>>> src/bgd_pkg.sv
// package for the button gesture detector: sizes, request codes and the
// command and status structs shared by the controller and the datapath
// no dependencies
package bgd_pkg;

  localparam int NUM_BUTTONS  = 7;
  localparam int HISTORY_BITS = 32;
  localparam int SRC_BITS     = 7;
  localparam int HOLD_W       = 8;
  localparam int BTN_W        = 8;
  localparam int WIN_W        = 8;
  localparam int IDX_W        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EXT_W        = (NUM_BUTTONS > SRC_BITS) ? NUM_BUTTONS : SRC_BITS;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  typedef logic [HISTORY_BITS-1:0] hist_t;
  typedef logic [SRC_BITS-1:0]     src_t;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_HOLD   = 2'd1,
    REQ_DOUBLE = 2'd2,
    REQ_CHORD  = 2'd3
  } req_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic rd_first;
    logic rd_second;
    logic eval;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tick;
    logic is_chord;
  } dp_sts_t;

  // mask of the low w history bits, all ones once w reaches the width
  function automatic hist_t hist_mask(input logic [WIN_W-1:0] w);
    hist_t m;
    for (int j = 0; j < HISTORY_BITS; j++) begin
      m[j] = (j < int'(w));
    end
    return m;
  endfunction

endpackage

>>> src/bgd_if.sv
// request and response channel interfaces of the button gesture detector
// depends on bgd_pkg
interface bgd_req_if;
  import bgd_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [SRC_BITS-1:0] key_now;
  logic [SRC_BITS-1:0] pad_now;
  logic [BTN_W-1:0]    first_button;
  logic [BTN_W-1:0]    second_button;
  logic [WIN_W-1:0]    frame_window;

  modport source (
    output valid, req_type, key_now, pad_now, first_button, second_button, frame_window,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_now, pad_now, first_button, second_button, frame_window,
    output ready
  );
endinterface

interface bgd_rsp_if;
  import bgd_pkg::*;

  logic                valid;
  logic                ready;
  logic                answer;
  logic                bad_request;
  logic [SRC_BITS-1:0] press_edges;
  logic [SRC_BITS-1:0] held_bits;

  modport source (
    output valid, answer, bad_request, press_edges, held_bits,
    input  ready
  );
  modport sink (
    input  valid, answer, bad_request, press_edges, held_bits,
    output ready
  );
endinterface

>>> src/bgd_dp.sv
// datapath: button state (past samples, hold counters, tap and chord
// histories), captured request, operand registers, result and output registers
// depends on bgd_pkg
module bgd_dp import bgd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [1:0]          req_type_i,
  input  logic [SRC_BITS-1:0] key_now_i,
  input  logic [SRC_BITS-1:0] pad_now_i,
  input  logic [BTN_W-1:0]    first_button_i,
  input  logic [BTN_W-1:0]    second_button_i,
  input  logic [WIN_W-1:0]    frame_window_i,
  output logic                answer_o,
  output logic                bad_request_o,
  output logic [SRC_BITS-1:0] press_edges_o,
  output logic [SRC_BITS-1:0] held_bits_o
);

  // button state
  src_t              key_past_q, pad_past_q;
  logic [HOLD_W-1:0] hold_q  [NUM_BUTTONS];
  hist_t             tap_q   [NUM_BUTTONS];
  hist_t             chord_q [NUM_BUTTONS];

  // captured request
  req_e              type_q;
  src_t              kn_q, pn_q;
  logic [BTN_W-1:0]  b1_q, b2_q;
  logic [WIN_W-1:0]  w_q;

  // operands and result
  hist_t             op1_q, op2_q;
  logic              res_ans_q, res_bad_q;
  src_t              res_edges_q, res_held_q;
  logic              out_ans_q, out_bad_q;
  src_t              out_edges_q, out_held_q;

  src_t              tick_edges, tick_held;
  logic [EXT_W-1:0]  edges_ext, held_ext;
  logic              b1_ok, b2_ok;
  logic [IDX_W-1:0]  idx1, idx2;
  hist_t             win_mask;
  logic              eval_bad, eval_ans;

  // press edge and held bits of the captured tick
  assign tick_edges = (kn_q & ~key_past_q) | (pn_q & ~pad_past_q);
  assign tick_held  = (kn_q & key_past_q) | (pn_q & pad_past_q);
  assign edges_ext  = EXT_W'(tick_edges);
  assign held_ext   = EXT_W'(tick_held);

  // button index range checks and safe read indexes
  assign b1_ok    = (b1_q < BTN_W'(NUM_BUTTONS));
  assign b2_ok    = (b2_q < BTN_W'(NUM_BUTTONS));
  assign idx1     = b1_ok ? b1_q[IDX_W-1:0] : '0;
  assign idx2     = b2_ok ? b2_q[IDX_W-1:0] : '0;
  assign win_mask = hist_mask(w_q);

  // argument check and answer of the query
  always_comb begin
    eval_bad = 1'b0;
    eval_ans = 1'b0;
    case (type_q)
      REQ_HOLD: begin
        eval_bad = !b1_ok || (w_q == '0);
        eval_ans = (hold_q[idx1] >= w_q);
      end
      REQ_DOUBLE: begin
        eval_bad = !b1_ok || (w_q < WIN_W'(2)) || (w_q >= WIN_W'(HISTORY_BITS));
        eval_ans = |(op1_q & (op1_q - hist_t'(1)));
      end
      REQ_CHORD: begin
        eval_bad = !b1_ok || !b2_ok || (b1_q == b2_q) || (w_q == '0) ||
                   (w_q > WIN_W'(HISTORY_BITS));
        eval_ans = (|op1_q) && (|op2_q);
      end
      default: begin
        eval_bad = 1'b0;
        eval_ans = 1'b0;
      end
    endcase
    if (eval_bad) begin
      eval_ans = 1'b0;
    end
  end

  // ticks update button state; successful double/chord queries clear history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_past_q <= '0;
      pad_past_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hold_q[i]  <= '0;
        tap_q[i]   <= '0;
        chord_q[i] <= '0;
      end
    end else if (cmd_i.tick) begin
      key_past_q <= kn_q;
      pad_past_q <= pn_q;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        tap_q[i]   <= {tap_q[i][HISTORY_BITS-2:0], edges_ext[i]};
        chord_q[i] <= {chord_q[i][HISTORY_BITS-2:0], edges_ext[i]};
        if (held_ext[i]) begin
          if (hold_q[i] != HOLD_MAX) begin
            hold_q[i] <= hold_q[i] + HOLD_W'(1);
          end
        end else begin
          hold_q[i] <= '0;
        end
      end
    end else if (cmd_i.eval && eval_ans) begin
      if (type_q == REQ_DOUBLE) begin
        tap_q[idx1] <= '0;
      end else if (type_q == REQ_CHORD) begin
        chord_q[idx1] <= '0;
        chord_q[idx2] <= '0;
      end
    end
  end

  // request capture, operand reads and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q <= req_e'(req_type_i);
      kn_q   <= key_now_i;
      pn_q   <= pad_now_i;
      b1_q   <= first_button_i;
      b2_q   <= second_button_i;
      w_q    <= frame_window_i;
    end
    if (cmd_i.rd_first) begin
      op1_q <= ((type_q == REQ_DOUBLE) ? tap_q[idx1] : chord_q[idx1]) & win_mask;
    end
    if (cmd_i.rd_second) begin
      op2_q <= chord_q[idx2] & win_mask;
    end
    if (cmd_i.tick) begin
      res_ans_q   <= 1'b0;
      res_bad_q   <= 1'b0;
      res_edges_q <= tick_edges;
      res_held_q  <= tick_held;
    end else if (cmd_i.eval) begin
      res_ans_q   <= eval_ans;
      res_bad_q   <= eval_bad;
      res_edges_q <= '0;
      res_held_q  <= '0;
    end
    if (cmd_i.load_out) begin
      out_ans_q   <= res_ans_q;
      out_bad_q   <= res_bad_q;
      out_edges_q <= res_edges_q;
      out_held_q  <= res_held_q;
    end
  end

  assign sts_o.in_is_tick = (req_e'(req_type_i) == REQ_TICK);
  assign sts_o.is_chord   = (type_q == REQ_CHORD);

  assign answer_o      = out_ans_q;
  assign bad_request_o = out_bad_q;
  assign press_edges_o = out_edges_q;
  assign held_bits_o   = out_held_q;

endmodule

>>> src/bgd_ctrl.sv
// controller: sequences capture, tick update or query reads and evaluation,
// and owns the handshakes and the output slot
// depends on bgd_pkg
module bgd_ctrl import bgd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_RD1,
    S_RD2,
    S_EVAL,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.in_is_tick ? S_TICK : S_RD1;
        end
      end
      S_TICK: begin
        cmd_o.tick = 1'b1;
        state_d = S_RESULT;
      end
      S_RD1: begin
        cmd_o.rd_first = 1'b1;
        state_d = sts_i.is_chord ? S_RD2 : S_EVAL;
      end
      S_RD2: begin
        cmd_o.rd_second = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> src/button_gesture_detector.sv
// top level of the button gesture detector: controller plus datapath
// depends on bgd_pkg, bgd_if, bgd_ctrl, bgd_dp
//
//   channel | direction | carries
//   --------+-----------+-------------------------------------------------
//   req_i   | in        | req_type, key_now, pad_now, buttons, frame_window
//   rsp_o   | out       | answer, bad_request, press_edges, held_bits
//
// one transaction is handled at a time; every request gives one response
// a tick passes through the capture, tick update and result states; a query
// through capture, one register read per button index, evaluation and result
// (the result state waits for a free slot, then fills the output register)
// the output register holds one response while the next request is taken
// reset clears all button state at once; no warm-up pass
module button_gesture_detector import bgd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bgd_req_if.sink  req_i,
  bgd_rsp_if.source rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  bgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  bgd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .req_type_i      (req_i.req_type),
    .key_now_i       (req_i.key_now),
    .pad_now_i       (req_i.pad_now),
    .first_button_i  (req_i.first_button),
    .second_button_i (req_i.second_button),
    .frame_window_i  (req_i.frame_window),
    .answer_o        (rsp_o.answer),
    .bad_request_o   (rsp_o.bad_request),
    .press_edges_o   (rsp_o.press_edges),
    .held_bits_o     (rsp_o.held_bits)
  );

endmodule

>>> src/bgd_chk.sv
// port-level checker for the button gesture detector, bound to the top level
// depends on bgd_pkg
module bgd_chk import bgd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                answer_i,
  input logic                bad_request_i,
  input logic [SRC_BITS-1:0] press_edges_i,
  input logic [SRC_BITS-1:0] held_bits_i
);

  // a request is in flight right after it is taken
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i
  ) else $error("request taken while previous one in flight");

  // a response is never dropped before it is taken
  a_rsp_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
  ) else $error("response withdrawn before transaction");

  // query responses with answer or bad_request set carry no tick bits
  a_query_no_tick_bits: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (answer_i || bad_request_i) |-> press_edges_i == '0 && held_bits_i == '0
  ) else $error("query response with tick bits");

  // a rejected query never answers true
  a_bad_no_answer: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_request_i |-> !answer_i
  ) else $error("answer set on bad request");

endmodule

bind button_gesture_detector bgd_chk u_bgd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .answer_i      (rsp_o.answer),
  .bad_request_i (rsp_o.bad_request),
  .press_edges_i (rsp_o.press_edges),
  .held_bits_i   (rsp_o.held_bits)
);

>>> verif/tb_top.sv
// self-checking testbench for button_gesture_detector: queued request driver,
// response monitor and an in-bench gesture predictor with its own button state
// depends on bgd_pkg, bgd_if and the detector rtl
`timescale 1ns / 100ps

module tb_top;
  import bgd_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int ITEM_TARGET     = 600;
  localparam int IDLE_PCT        = 9;
  localparam int CALM_FROM       = 350;
  localparam int CALM_TO         = 470;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 50;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct packed {
    req_e             kind;
    src_t             key;
    src_t             pad;
    logic [BTN_W-1:0] btn_a;
    logic [BTN_W-1:0] btn_b;
    logic [WIN_W-1:0] window;
  } gesture_req_t;

  typedef struct packed {
    logic answer;
    logic bad;
    src_t edges;
    src_t held;
  } gesture_rsp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bgd_req_if gesture_req ();
  bgd_rsp_if gesture_rsp ();

  // testbench-side drive registers, known from time zero
  logic         req_valid  = 1'b0;
  gesture_req_t req_drive  = '0;
  logic         sink_ready = 1'b0;
  logic         hold_off   = 1'b0;

  assign gesture_req.valid         = req_valid;
  assign gesture_req.req_type      = req_drive.kind;
  assign gesture_req.key_now       = req_drive.key;
  assign gesture_req.pad_now       = req_drive.pad;
  assign gesture_req.first_button  = req_drive.btn_a;
  assign gesture_req.second_button = req_drive.btn_b;
  assign gesture_req.frame_window  = req_drive.window;
  assign gesture_rsp.ready         = sink_ready;

  button_gesture_detector i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (gesture_req),
    .rsp_o  (gesture_rsp)
  );

  gesture_req_t queued_requests [$];
  gesture_rsp_t awaited_answers [$];
  gesture_rsp_t want;

  int n_offered   = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int cycle_count = 0;

  logic calm;
  assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

  // predictor copy of the button state
  src_t              key_last = '0;
  src_t              pad_last = '0;
  logic [HOLD_W-1:0] held_frames [NUM_BUTTONS] = '{default: '0};
  hist_t             tap_bits    [NUM_BUTTONS] = '{default: '0};
  hist_t             chord_bits  [NUM_BUTTONS] = '{default: '0};

  // generator view of the pressed bits of the last queued tick
  src_t gen_key = '0;
  src_t gen_pad = '0;

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // apply one request to the predicted state and return its response
  function automatic gesture_rsp_t predict_gesture(input gesture_req_t r);
    gesture_rsp_t o;
    src_t         rise_v;
    src_t         held_v;
    hist_t        win;
    hist_t        taps;
    logic         rise;
    logic         hold;
    o = '0;
    win = (r.window >= HISTORY_BITS) ? '1 : ((hist_t'(1) << r.window) - hist_t'(1));
    case (r.kind)
      REQ_TICK: begin
        rise_v = (r.key & ~key_last) | (r.pad & ~pad_last);
        held_v = (r.key & key_last) | (r.pad & pad_last);
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          rise = (i < SRC_BITS) ? rise_v[i] : 1'b0;
          hold = (i < SRC_BITS) ? held_v[i] : 1'b0;
          tap_bits[i]   = {tap_bits[i][HISTORY_BITS-2:0], rise};
          chord_bits[i] = {chord_bits[i][HISTORY_BITS-2:0], rise};
          if (hold) begin
            if (held_frames[i] != HOLD_MAX) held_frames[i] = held_frames[i] + HOLD_W'(1);
          end else begin
            held_frames[i] = '0;
          end
        end
        key_last = r.key;
        pad_last = r.pad;
        o.edges  = rise_v;
        o.held   = held_v;
      end
      REQ_HOLD: begin
        if (r.btn_a >= NUM_BUTTONS || r.window == '0) begin
          o.bad = 1'b1;
        end else begin
          o.answer = (held_frames[r.btn_a] >= r.window);
        end
      end
      REQ_DOUBLE: begin
        if (r.btn_a >= NUM_BUTTONS || r.window < 2 || r.window >= HISTORY_BITS) begin
          o.bad = 1'b1;
        end else begin
          taps = tap_bits[r.btn_a] & win;
          if ($countones(taps) >= 2) begin
            o.answer = 1'b1;
            tap_bits[r.btn_a] = '0;
          end
        end
      end
      REQ_CHORD: begin
        if (r.btn_a >= NUM_BUTTONS || r.btn_b >= NUM_BUTTONS || r.btn_a == r.btn_b ||
            r.window == '0 || r.window > HISTORY_BITS) begin
          o.bad = 1'b1;
        end else if ((chord_bits[r.btn_a] & win) != '0 &&
                     (chord_bits[r.btn_b] & win) != '0) begin
          o.answer = 1'b1;
          chord_bits[r.btn_a] = '0;
          chord_bits[r.btn_b] = '0;
        end
      end
    endcase
    return o;
  endfunction

  // queue a frame tick; the button and window fields are don't-care
  task automatic push_tick(input src_t k, input src_t p);
    gesture_req_t r;
    r.kind   = REQ_TICK;
    r.key    = k;
    r.pad    = p;
    r.btn_a  = BTN_W'($urandom);
    r.btn_b  = BTN_W'($urandom);
    r.window = WIN_W'($urandom);
    queued_requests.push_back(r);
    gen_key = k;
    gen_pad = p;
  endtask

  // queue a query; the source bits are don't-care
  task automatic push_query(input req_e kind, input int a, input int b, input int w);
    gesture_req_t r;
    r.kind   = kind;
    r.key    = src_t'($urandom);
    r.pad    = src_t'($urandom);
    r.btn_a  = BTN_W'(a);
    r.btn_b  = BTN_W'(b);
    r.window = WIN_W'(w);
    queued_requests.push_back(r);
  endtask

  // tick with one button moved on one source, everything else unchanged
  task automatic press_button(input int b, input bit via_pad, input bit down);
    src_t k;
    src_t p;
    k = gen_key;
    p = gen_pad;
    if (via_pad) p[b] = down;
    else k[b] = down;
    push_tick(k, p);
  endtask

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("tb_top: mismatch at response %0d: %0s", n_checked, msg);
  endtask

  // request driver: next queued transaction at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (n_offered == n_accepted) begin
      if (queued_requests.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req_drive <= queued_requests.pop_front();
        req_valid <= 1'b1;
        n_offered++;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // accepted request: predict its response
  always @(posedge clk) begin
    if (rst_n && gesture_req.valid && gesture_req.ready) begin
      awaited_answers.push_back(predict_gesture(req_drive));
      n_accepted++;
    end
  end

  // response sink ready, with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : back_pressure
    while (n_accepted < HOLD_OFF_AT) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && gesture_rsp.valid && gesture_rsp.ready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = awaited_answers.pop_front();
        if (gesture_rsp.answer !== want.answer)
          report_mismatch($sformatf("answer %b, expected %b", gesture_rsp.answer, want.answer));
        if (gesture_rsp.bad_request !== want.bad)
          report_mismatch($sformatf("bad_request %b, expected %b",
                                    gesture_rsp.bad_request, want.bad));
        if (gesture_rsp.press_edges !== want.edges)
          report_mismatch($sformatf("press_edges %h, expected %h",
                                    gesture_rsp.press_edges, want.edges));
        if (gesture_rsp.held_bits !== want.held)
          report_mismatch($sformatf("held_bits %h, expected %h",
                                    gesture_rsp.held_bits, want.held));
      end
      n_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout with %0d responses outstanding", awaited_answers.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int b1;
    int b2;
    int n;
    int pick;
    bit side;

    // directed: source extremes, hold and double press corners, chord corners
    push_tick(7'h7f, 7'h00);
    push_tick(7'h7f, 7'h7f);
    push_tick(7'h00, 7'h7f);
    push_query(REQ_HOLD, 0, 0, 1);
    push_query(REQ_HOLD, 6, 0, 2);
    push_query(REQ_HOLD, 0, 0, 0);
    push_query(REQ_HOLD, NUM_BUTTONS, 0, 1);
    push_query(REQ_HOLD, 255, 255, 255);
    push_query(REQ_DOUBLE, 1, 0, 3);
    push_query(REQ_DOUBLE, 1, 0, 3);
    push_query(REQ_DOUBLE, 2, 0, 2);
    push_query(REQ_DOUBLE, 2, 0, 1);
    push_query(REQ_DOUBLE, 2, 0, HISTORY_BITS);
    push_query(REQ_DOUBLE, 3, 0, HISTORY_BITS - 1);
    push_query(REQ_DOUBLE, NUM_BUTTONS, 0, 5);
    push_query(REQ_CHORD, 4, 5, HISTORY_BITS);
    push_query(REQ_CHORD, 5, 6, 1);
    push_query(REQ_CHORD, 6, 6, 4);
    push_query(REQ_CHORD, 0, NUM_BUTTONS, 4);
    push_query(REQ_CHORD, 255, 0, 4);
    push_query(REQ_CHORD, 0, 6, 0);
    push_query(REQ_CHORD, 0, 6, HISTORY_BITS + 1);
    push_query(REQ_CHORD, 0, 6, 255);
    push_tick(7'h00, 7'h00);
    push_query(REQ_CHORD, 0, 6, HISTORY_BITS);

    // long hold on the key source up to counter saturation
    push_tick(src_t'($urandom_range(1, 127)), 7'h00);
    repeat (int'(HOLD_MAX) + 3) push_tick(gen_key, src_t'($urandom));
    for (int i = 0; i < NUM_BUTTONS; i++) push_query(REQ_HOLD, i, 0, int'(HOLD_MAX));
    push_query(REQ_HOLD, 0, 0, 1);
    push_tick(7'h00, 7'h00);

    // random gestures, mostly well formed, some noise
    while (queued_requests.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      b1   = $urandom_range(0, NUM_BUTTONS - 1);
      side = 1'($urandom_range(0, 1));
      if (pick <= 2) begin
        // double press, second press possibly on the other source
        press_button(b1, side, 1'b1);
        press_button(b1, side, 1'b0);
        repeat ($urandom_range(0, 3)) push_tick(gen_key, gen_pad);
        side = side ^ 1'($urandom_range(0, 1));
        press_button(b1, side, 1'b1);
        press_button(b1, side, 1'b0);
        if ($urandom_range(0, 7) == 0) b1 = $urandom_range(0, NUM_BUTTONS - 1);
        push_query(REQ_DOUBLE, b1, $urandom_range(0, 255),
                   $urandom_range(0, 1) ? $urandom_range(2, 8)
                                        : $urandom_range(2, HISTORY_BITS - 1));
      end else if (pick <= 5) begin
        // chord of two distinct buttons, a few frames apart
        b2 = (b1 + $urandom_range(1, NUM_BUTTONS - 1)) % NUM_BUTTONS;
        press_button(b1, 1'b0, 1'b1);
        repeat ($urandom_range(0, 2)) push_tick(gen_key, gen_pad);
        press_button(b2, 1'b1, 1'b1);
        press_button(b1, 1'b0, 1'b0);
        press_button(b2, 1'b1, 1'b0);
        n = $urandom_range(0, 1) ? $urandom_range(1, 10) : $urandom_range(1, HISTORY_BITS);
        if ($urandom_range(0, 1)) push_query(REQ_CHORD, b1, b2, n);
        else push_query(REQ_CHORD, b2, b1, n);
      end else if (pick <= 7) begin
        // hold for a number of frames, query around that count
        press_button(b1, side, 1'b1);
        n = $urandom_range(1, 20);
        repeat (n) push_tick(gen_key, gen_pad);
        push_query(REQ_HOLD, b1, $urandom_range(0, 255), $urandom_range(1, n + 3));
        press_button(b1, side, 1'b0);
      end else if ($urandom_range(0, 2) == 0) begin
        push_tick(src_t'($urandom), src_t'($urandom));
      end else begin
        push_query(req_e'(2'($urandom_range(1, 3))),
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, NUM_BUTTONS),
                   $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, NUM_BUTTONS),
                   $urandom_range(0, 1) ? $urandom_range(0, 255)
                                        : $urandom_range(0, HISTORY_BITS + 1));
      end
    end

    // reset, released away from the rising edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain
    while (queued_requests.size() != 0 || n_offered != n_accepted) @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bgd_pkg.sv
src/bgd_if.sv
src/bgd_dp.sv
src/bgd_ctrl.sv
src/button_gesture_detector.sv
src/bgd_chk.sv
verif/tb_top.sv
